@@ design/aoc_pkg.sv @@
// aoc_pkg: types and constants shared by the box contact pipeline
// transaction structs for both channels, stage payloads and face codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package aoc_pkg;

	localparam int CoordWidth = 32;
	localparam int AxisCount  = 3;
	localparam int FaceCount  = 6;
	localparam int AxisWidth  = 3;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic [CoordWidth-1:0] dist_t;
	typedef logic [AxisWidth-1:0] face_code_t;

	localparam face_code_t FACE_NEG_X = 3'd0;
	localparam face_code_t FACE_POS_X = 3'd1;
	localparam face_code_t FACE_NEG_Y = 3'd2;
	localparam face_code_t FACE_POS_Y = 3'd3;
	localparam face_code_t FACE_NEG_Z = 3'd4;
	localparam face_code_t FACE_POS_Z = 3'd5;

	typedef struct packed {
		coord_t a_min_x;
		coord_t a_min_y;
		coord_t a_min_z;
		coord_t a_max_x;
		coord_t a_max_y;
		coord_t a_max_z;
		coord_t b_min_x;
		coord_t b_min_y;
		coord_t b_min_z;
		coord_t b_max_x;
		coord_t b_max_y;
		coord_t b_max_z;
	} req_t;

	typedef struct packed {
		logic       hit;
		face_code_t contact_axis;
		dist_t      penetration;
		coord_t     contact_x;
		coord_t     contact_y;
		coord_t     contact_z;
	} rsp_t;

	// after the face stage
	typedef struct packed {
		logic [AxisCount-1:0]            overlap;
		logic [FaceCount-1:0][CoordWidth-1:0] depth;
		logic [AxisCount-1:0][CoordWidth-1:0] lo;
		logic [AxisCount-1:0][CoordWidth-1:0] hi;
	} face_t;

	// after the reduce stage
	typedef struct packed {
		logic                                  hit;
		logic [AxisCount-1:0][CoordWidth-1:0]  best_dist;
		logic [AxisCount-1:0][AxisWidth-1:0]   best_code;
		logic [AxisCount-1:0][CoordWidth-1:0]  center;
	} pair_t;

endpackage

`default_nettype wire

@@ design/aoc_face_stage.sv @@
// aoc_face_stage: first pipeline stage, per-axis overlap tests, face distances
// and overlap region bounds; depends on aoc_pkg
`timescale 1ns / 1ps
`default_nettype none

module aoc_face_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire aoc_pkg::req_t  req,
	input  wire logic           take_next,
	output logic                take,
	output logic                valid_s1,
	output aoc_pkg::face_t      face_s1
);

	aoc_pkg::coord_t amin [aoc_pkg::AxisCount];
	aoc_pkg::coord_t amax [aoc_pkg::AxisCount];
	aoc_pkg::coord_t bmin [aoc_pkg::AxisCount];
	aoc_pkg::coord_t bmax [aoc_pkg::AxisCount];
	aoc_pkg::face_t  face_d;

	assign take = !valid_s1 || take_next;

	always_comb begin
		amin[0] = req.a_min_x;
		amin[1] = req.a_min_y;
		amin[2] = req.a_min_z;
		amax[0] = req.a_max_x;
		amax[1] = req.a_max_y;
		amax[2] = req.a_max_z;
		bmin[0] = req.b_min_x;
		bmin[1] = req.b_min_y;
		bmin[2] = req.b_min_z;
		bmax[0] = req.b_max_x;
		bmax[1] = req.b_max_y;
		bmax[2] = req.b_max_z;
		for (int i = 0; i < aoc_pkg::AxisCount; i++) begin
			face_d.overlap[i] = (amin[i] <= bmax[i]) && (amax[i] >= bmin[i]);
			// only meaningful on a hit, where both fit unsigned
			face_d.depth[2*i]   = amax[i] - bmin[i];
			face_d.depth[2*i+1] = bmax[i] - amin[i];
			face_d.lo[i] = (amin[i] > bmin[i]) ? amin[i] : bmin[i];
			face_d.hi[i] = (amax[i] < bmax[i]) ? amax[i] : bmax[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && req_valid) begin
			face_s1 <= face_d;
		end
	end

endmodule

`default_nettype wire

@@ design/aoc_reduce_stage.sv @@
// aoc_reduce_stage: second pipeline stage, hit flag, per-axis face winner
// and center of the overlap region by floor halving; depends on aoc_pkg
`timescale 1ns / 1ps
`default_nettype none

module aoc_reduce_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s1,
	input  wire aoc_pkg::face_t  face_s1,
	input  wire logic            take_next,
	output logic                 take,
	output logic                 valid_s2,
	output aoc_pkg::pair_t       pair_s2
);

	localparam int W = aoc_pkg::CoordWidth;

	aoc_pkg::pair_t pair_d;
	logic [W:0]     sum [aoc_pkg::AxisCount];

	assign take = !valid_s2 || take_next;

	always_comb begin
		pair_d.hit = &face_s1.overlap;
		for (int i = 0; i < aoc_pkg::AxisCount; i++) begin
			sum[i] = {face_s1.lo[i][W-1], face_s1.lo[i]}
				+ {face_s1.hi[i][W-1], face_s1.hi[i]};
			pair_d.center[i] = sum[i][W:1];
			// lower face wins ties
			if (face_s1.depth[2*i+1] < face_s1.depth[2*i]) begin
				pair_d.best_dist[i] = face_s1.depth[2*i+1];
				pair_d.best_code[i] = aoc_pkg::AxisWidth'(2*i+1);
			end else begin
				pair_d.best_dist[i] = face_s1.depth[2*i];
				pair_d.best_code[i] = aoc_pkg::AxisWidth'(2*i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid_s1) begin
			pair_s2 <= pair_d;
		end
	end

endmodule

`default_nettype wire

@@ design/aoc_select_stage.sv @@
// aoc_select_stage: last pipeline stage, picks the smallest face over the
// three axis winners and zeroes a miss; depends on aoc_pkg
`timescale 1ns / 1ps
`default_nettype none

module aoc_select_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s2,
	input  wire aoc_pkg::pair_t  pair_s2,
	input  wire logic            take_next,
	output logic                 take,
	output logic                 valid_s3,
	output aoc_pkg::rsp_t        rsp_s3
);

	aoc_pkg::rsp_t       rsp_d;
	aoc_pkg::dist_t      xy_dist;
	aoc_pkg::face_code_t xy_code;

	assign take = !valid_s3 || take_next;

	always_comb begin
		if (pair_s2.best_dist[1] < pair_s2.best_dist[0]) begin
			xy_dist = pair_s2.best_dist[1];
			xy_code = pair_s2.best_code[1];
		end else begin
			xy_dist = pair_s2.best_dist[0];
			xy_code = pair_s2.best_code[0];
		end
		rsp_d = '0;
		if (pair_s2.hit) begin
			rsp_d.hit = 1'b1;
			if (pair_s2.best_dist[2] < xy_dist) begin
				rsp_d.penetration  = pair_s2.best_dist[2];
				rsp_d.contact_axis = pair_s2.best_code[2];
			end else begin
				rsp_d.penetration  = xy_dist;
				rsp_d.contact_axis = xy_code;
			end
			rsp_d.contact_x = pair_s2.center[0];
			rsp_d.contact_y = pair_s2.center[1];
			rsp_d.contact_z = pair_s2.center[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid_s2) begin
			rsp_s3 <= rsp_d;
		end
	end

endmodule

`default_nettype wire

@@ design/aabb_overlap_contact.sv @@
// aabb_overlap_contact: contact test for two axis-aligned boxes, top level
// path: an accepted transaction moves through valid_s1 and valid_s2 into valid_s3, which drives rsp_valid
// throughput: one transaction per cycle while rsp_stall is low, set by the three-stage pipeline
// stall: each stage refills as soon as its contents move on, so no bubbles
// reset: clears the stage valid bits only; payload registers are not reset
// depends on aoc_pkg, aoc_face_stage, aoc_reduce_stage, aoc_select_stage
`timescale 1ns / 1ps
`default_nettype none

module aabb_overlap_contact (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire aoc_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output aoc_pkg::rsp_t       rsp
);

	logic           take1, take2, take3;
	logic           valid_s1, valid_s2, valid_s3;
	aoc_pkg::face_t face_s1;
	aoc_pkg::pair_t pair_s2;
	aoc_pkg::rsp_t  rsp_s3;

	aoc_face_stage u_face (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.take_next (take2),
		.take      (take1),
		.valid_s1  (valid_s1),
		.face_s1   (face_s1)
	);

	aoc_reduce_stage u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.face_s1   (face_s1),
		.take_next (take3),
		.take      (take2),
		.valid_s2  (valid_s2),
		.pair_s2   (pair_s2)
	);

	aoc_select_stage u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.pair_s2   (pair_s2),
		.take_next (!rsp_stall),
		.take      (take3),
		.valid_s3  (valid_s3),
		.rsp_s3    (rsp_s3)
	);

	assign req_stall = !take1;
	assign rsp_valid = valid_s3;
	assign rsp       = rsp_s3;

	// a free output lets every stage move
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_stall |-> !req_stall)
		else $error("input stalled while output is free");

	// an accepted transaction lands in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> valid_s1)
		else $error("accepted transaction lost at first stage");

	// a miss carries nothing but zeros
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.hit) |-> (rsp.contact_axis == aoc_pkg::FACE_NEG_X
		&& rsp.penetration == '0 && rsp.contact_x == '0
		&& rsp.contact_y == '0 && rsp.contact_z == '0))
		else $error("miss with nonzero contact data");

	// the face code stays within the six faces
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.contact_axis <= aoc_pkg::FACE_POS_Z))
		else $error("contact axis out of range");

	// a middle stage that cannot drain holds its transaction
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !take3) |=> valid_s2)
		else $error("stalled transaction dropped in second stage");

endmodule

`default_nettype wire

@@ dv/aoc_contact_checker.sv @@
// aoc_contact_checker: watches both channels of the box contact block, predicts each result
// from the accepted request and compares field by field in arrival order
// depends on aoc_pkg
`timescale 1ns / 1ps
`default_nettype none

module aoc_contact_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_stall,
	input  wire aoc_pkg::req_t  req,
	input  wire logic           rsp_valid,
	input  wire logic           rsp_stall,
	input  wire aoc_pkg::rsp_t  rsp,
	output int                  mismatches,
	output int                  outstanding
);

	aoc_pkg::rsp_t expected_contacts[$];

	function automatic aoc_pkg::rsp_t predict_contact(input aoc_pkg::req_t p);
		aoc_pkg::face_code_t face_of [aoc_pkg::FaceCount] = '{aoc_pkg::FACE_NEG_X,
			aoc_pkg::FACE_POS_X, aoc_pkg::FACE_NEG_Y, aoc_pkg::FACE_POS_Y,
			aoc_pkg::FACE_NEG_Z, aoc_pkg::FACE_POS_Z};
		longint amn [aoc_pkg::AxisCount];
		longint amx [aoc_pkg::AxisCount];
		longint bmn [aoc_pkg::AxisCount];
		longint bmx [aoc_pkg::AxisCount];
		longint depth [aoc_pkg::FaceCount];
		longint lo_edge, hi_edge;
		aoc_pkg::coord_t center [aoc_pkg::AxisCount];
		aoc_pkg::rsp_t r;
		bit overlap;
		int best;
		amn[0] = p.a_min_x; amn[1] = p.a_min_y; amn[2] = p.a_min_z;
		amx[0] = p.a_max_x; amx[1] = p.a_max_y; amx[2] = p.a_max_z;
		bmn[0] = p.b_min_x; bmn[1] = p.b_min_y; bmn[2] = p.b_min_z;
		bmx[0] = p.b_max_x; bmx[1] = p.b_max_y; bmx[2] = p.b_max_z;
		r = '0;
		overlap = 1'b1;
		for (int i = 0; i < aoc_pkg::AxisCount; i++) begin
			if (!(amn[i] <= bmx[i] && amx[i] >= bmn[i]))
				overlap = 1'b0;
		end
		if (!overlap)
			return r;
		for (int i = 0; i < aoc_pkg::AxisCount; i++) begin
			depth[2*i]     = amx[i] - bmn[i];
			depth[2*i + 1] = bmx[i] - amn[i];
			lo_edge = (amn[i] > bmn[i]) ? amn[i] : bmn[i];
			hi_edge = (amx[i] < bmx[i]) ? amx[i] : bmx[i];
			center[i] = aoc_pkg::coord_t'((lo_edge + hi_edge) >>> 1);
		end
		best = 0;
		for (int i = 1; i < aoc_pkg::FaceCount; i++) begin
			if (depth[i] < depth[best])
				best = i;
		end
		r.hit          = 1'b1;
		r.contact_axis = face_of[best];
		r.penetration  = aoc_pkg::dist_t'(depth[best]);
		r.contact_x    = center[0];
		r.contact_y    = center[1];
		r.contact_z    = center[2];
		return r;
	endfunction

	function automatic int count_diffs(input aoc_pkg::rsp_t want, input aoc_pkg::rsp_t got);
		int errs;
		errs = 0;
		if (got.hit !== want.hit) begin
			$display("%0t hit mismatch: expected %h actual %h", $time, want.hit, got.hit);
			errs++;
		end
		if (got.contact_axis !== want.contact_axis) begin
			$display("%0t contact_axis mismatch: expected %0d actual %0d", $time,
				want.contact_axis, got.contact_axis);
			errs++;
		end
		if (got.penetration !== want.penetration) begin
			$display("%0t penetration mismatch: expected %h actual %h", $time,
				want.penetration, got.penetration);
			errs++;
		end
		if (got.contact_x !== want.contact_x) begin
			$display("%0t contact_x mismatch: expected %h actual %h", $time,
				want.contact_x, got.contact_x);
			errs++;
		end
		if (got.contact_y !== want.contact_y) begin
			$display("%0t contact_y mismatch: expected %h actual %h", $time,
				want.contact_y, got.contact_y);
			errs++;
		end
		if (got.contact_z !== want.contact_z) begin
			$display("%0t contact_z mismatch: expected %h actual %h", $time,
				want.contact_z, got.contact_z);
			errs++;
		end
		return errs;
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		aoc_pkg::rsp_t want;
		int errs;
		if (!arst_n) begin
			expected_contacts.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			if (rsp_valid && !rsp_stall) begin
				if (expected_contacts.size() == 0) begin
					$display("%0t unexpected transaction: expected none actual %h", $time, rsp);
					errs++;
				end else begin
					want = expected_contacts.pop_front();
					errs += count_diffs(want, rsp);
				end
			end
			if (req_valid && !req_stall)
				expected_contacts.insert(expected_contacts.size(), predict_contact(req));
			mismatches  <= mismatches + errs;
			outstanding <= expected_contacts.size();
		end
	end

endmodule

`default_nettype wire

@@ dv/aabb_overlap_contact_tb.sv @@
// aabb_overlap_contact_tb: drives box pairs into the contact block with bursty traffic and
// random output stalls, then judges by the checker's mismatch and outstanding counts
// depends on aoc_pkg, aabb_overlap_contact, aoc_contact_checker
`timescale 1ns / 1ps
`default_nettype none

module aabb_overlap_contact_tb;

	localparam int              IdleLimit   = 3000;
	localparam int              RandomPairs = 700;
	localparam int              HoldCycles  = 300;
	localparam aoc_pkg::coord_t CoordMin    = {1'b1, {(aoc_pkg::CoordWidth-1){1'b0}}};
	localparam aoc_pkg::coord_t CoordMax    = {1'b0, {(aoc_pkg::CoordWidth-1){1'b1}}};
	localparam aoc_pkg::coord_t One         = 32'h0001_0000;

	typedef enum {PAIR_OVERLAP, PAIR_MISS, PAIR_NOISE} pair_kind_t;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	aoc_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	aoc_pkg::rsp_t rsp;
	logic          hold_rsp;
	int            mismatches;
	int            outstanding;
	int            idle_cycles = 0;
	int            burst_left = 0;
	bit            hold_burst = 0;

	aabb_overlap_contact uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	aoc_contact_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic aoc_pkg::req_t with_axis(input aoc_pkg::req_t p, input int ax,
		input aoc_pkg::coord_t amn, input aoc_pkg::coord_t amx,
		input aoc_pkg::coord_t bmn, input aoc_pkg::coord_t bmx);
		case (ax)
			0: begin
				p.a_min_x = amn; p.a_max_x = amx; p.b_min_x = bmn; p.b_max_x = bmx;
			end
			1: begin
				p.a_min_y = amn; p.a_max_y = amx; p.b_min_y = bmn; p.b_max_y = bmx;
			end
			default: begin
				p.a_min_z = amn; p.a_max_z = amx; p.b_min_z = bmn; p.b_max_z = bmx;
			end
		endcase
		return p;
	endfunction

	function automatic aoc_pkg::req_t uniform_pair(input aoc_pkg::coord_t amn,
		input aoc_pkg::coord_t amx, input aoc_pkg::coord_t bmn, input aoc_pkg::coord_t bmx);
		aoc_pkg::req_t p;
		p = '0;
		for (int ax = 0; ax < aoc_pkg::AxisCount; ax++)
			p = with_axis(p, ax, amn, amx, bmn, bmx);
		return p;
	endfunction

	// mostly small magnitudes so that ties and touching faces come up often
	function automatic aoc_pkg::coord_t pick_coord();
		aoc_pkg::coord_t v;
		case ($urandom_range(0, 11))
			0: v = CoordMin;
			1: v = CoordMax;
			2: v = '0;
			default: v = aoc_pkg::coord_t'($urandom) >>> $urandom_range(0, 31);
		endcase
		return v;
	endfunction

	function automatic aoc_pkg::req_t random_pair(input pair_kind_t kind);
		aoc_pkg::req_t p;
		aoc_pkg::coord_t s [4];
		aoc_pkg::coord_t t, amn, amx, bmn, bmx;
		int miss_axis;
		p = '0;
		miss_axis = (kind == PAIR_MISS) ? $urandom_range(0, 2) : -1;
		for (int ax = 0; ax < aoc_pkg::AxisCount; ax++) begin
			if (kind == PAIR_NOISE) begin
				p = with_axis(p, ax, $urandom, $urandom, $urandom, $urandom);
			end else begin
				for (int k = 0; k < 4; k++)
					s[k] = pick_coord();
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3 - i; j++) begin
						if (s[j] > s[j+1]) begin
							t = s[j]; s[j] = s[j+1]; s[j+1] = t;
						end
					end
				end
				if (ax == miss_axis) begin
					if ($urandom_range(0, 1)) begin
						amn = s[0]; amx = s[1]; bmn = s[2]; bmx = s[3];
					end else begin
						amn = s[2]; amx = s[3]; bmn = s[0]; bmx = s[1];
					end
				end else begin
					case ($urandom_range(0, 4))
						0: begin amn = s[0]; amx = s[2]; bmn = s[1]; bmx = s[3]; end
						1: begin amn = s[1]; amx = s[3]; bmn = s[0]; bmx = s[2]; end
						2: begin amn = s[0]; amx = s[3]; bmn = s[1]; bmx = s[2]; end
						3: begin amn = s[1]; amx = s[2]; bmn = s[0]; bmx = s[3]; end
						default: begin amn = s[0]; amx = s[1]; bmn = s[1]; bmx = s[2]; end
					endcase
				end
				// now and then an inverted box
				if ($urandom_range(0, 19) == 0) begin
					t = amn; amn = amx; amx = t;
				end
				if ($urandom_range(0, 19) == 0) begin
					t = bmn; bmn = bmx; bmx = t;
				end
				p = with_axis(p, ax, amn, amx, bmn, bmx);
			end
		end
		return p;
	endfunction

	// offer one transaction, then either continue the burst or open a gap
	task automatic offer_pair(input aoc_pkg::req_t item);
		bit taken;
		req       <= item;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end while (!taken);
		if (burst_left > 0 || hold_burst) begin
			if (burst_left > 0)
				burst_left--;
		end else begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	initial begin : stimulus
		aoc_pkg::req_t p;
		pair_kind_t kind;
		int pick;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		hold_rsp  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs
		offer_pair(uniform_pair(0, One, 0, One));
		for (int k = 0; k < aoc_pkg::FaceCount; k++) begin
			p = uniform_pair(0, 10*One, 0, 10*One);
			if (k % 2 == 0)
				p = with_axis(p, k / 2, 0, 10*One, 8*One, 20*One);
			else
				p = with_axis(p, k / 2, 8*One, 20*One, 0, 10*One);
			offer_pair(p);
		end
		offer_pair(with_axis(uniform_pair(0, One, 0, One), 0, 0, One, One, 2*One));
		for (int ax = 0; ax < aoc_pkg::AxisCount; ax++)
			offer_pair(with_axis(uniform_pair(0, One, 0, One), ax, 0, One, 2*One, 3*One));
		offer_pair(with_axis(uniform_pair(0, One, 0, One), 2, 2*One, 3*One, 0, One));
		offer_pair(uniform_pair(CoordMin, CoordMax, CoordMin, CoordMax));
		offer_pair(uniform_pair(CoordMin, CoordMin, CoordMin, CoordMax));
		offer_pair(uniform_pair(CoordMax, CoordMax, CoordMin, CoordMax));
		offer_pair(uniform_pair(CoordMax, CoordMax, CoordMin, CoordMin));
		offer_pair(uniform_pair(CoordMin, CoordMax, CoordMax, CoordMin));
		offer_pair(uniform_pair(5, -5, -10, 10));
		offer_pair(uniform_pair(-3, -1, -2, 0));

		// random pairs
		for (int n = 0; n < RandomPairs; n++) begin
			if (n == 250) begin
				hold_rsp  <= 1'b1;
				hold_burst = 1'b1;
			end
			if (n == 290)
				hold_burst = 1'b0;
			if (n == 500) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 9);
			kind = (pick < 7) ? PAIR_OVERLAP : (pick == 7) ? PAIR_MISS : PAIR_NOISE;
			offer_pair(random_pair(kind));
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : result_side
		stall_mode_t mode;
		int left;
		bit held;
		held = 1'b0;
		left = 0;
		mode = STALL_NONE;
		rsp_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_rsp && !held) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					left = $urandom_range(10, 80);
				end
				left--;
				case (mode)
					STALL_NONE:  rsp_stall <= 1'b0;
					STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
					STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
					default:     rsp_stall <= left[1];
				endcase
				@(posedge clk);
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire
